// ----- design/tlr_pkg.sv -----
// shared types, codes and helpers for the timed level ramp
`default_nettype none

package tlr_pkg;

    localparam int PERIOD_BITS_DEF = 16;
    localparam int LEVEL_W         = 7;
    localparam int STEP_W          = 8;
    localparam int TICK_W          = 16;
    localparam int CFG_ADDR_W      = 2;
    localparam int CFG_DATA_W      = 16;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 7'd100;

    // request codes
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_START = 2'd1;
    localparam logic [1:0] REQ_STOP  = 2'd2;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_RAMP_STEP   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_RAMP_TARGET = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_TICK_PERIOD = 2'd2;

    typedef struct packed {
        logic [1:0]         req_type;
        logic               load_level;
        logic [LEVEL_W-1:0] start_level;
    } in_beat_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level_out;
        logic               ramp_done;
        logic               ramping;
    } out_beat_t;

    typedef struct packed {
        logic [STEP_W-1:0]  ramp_step;
        logic [LEVEL_W-1:0] ramp_target;
        logic [TICK_W-1:0]  tick_period;
    } cfg_t;

    typedef struct packed {
        logic      valid;
        out_beat_t beat;
    } res_t;

    function automatic logic [LEVEL_W-1:0] clamp_level(input logic [LEVEL_W-1:0] v);
        clamp_level = (v > LEVEL_MAX) ? LEVEL_MAX : v;
    endfunction

endpackage

`default_nettype wire

// ----- design/timed_level_ramp_top.sv -----
// top level of the timed light level ramp generator
// usage:
//   s_ channel carries request beats: tick, start or stop, with an optional
//   start level. m_ channel carries level beats for the light driver, with
//   ramp_done on the final target value and ramping giving the phase after
//   the request. many requests make no beat at all (idle ticks, stops,
//   countdown ticks, aborts).
//   cfg_we/cfg_addr/cfg_wdata write one of ramp_step (0), ramp_target (1)
//   or tick_period (2) per write; write only while the block is idle.
// timing:
//   a request is taken into the input register, then updated against the
//   ramp state and its beat lands in the output register, driving m_valid.
//   one request per cycle is sustained; the only limit is the output
//   register, which holds a beat until m_ready.
// stall: while m_ready is low and a beat waits, the input register keeps
//   one more request and s_ready drops once both stages are full.
// reset: aresetn (sync, active low) clears the channels, the ramp to
//   dormant at level zero, and the registers to step 1, target 0, period 1.
`default_nettype none

module timed_level_ramp_top #(
    parameter int PERIOD_BITS = tlr_pkg::PERIOD_BITS_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire tlr_pkg::in_beat_t                   s_payload,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output tlr_pkg::out_beat_t                       m_payload,
    input  wire logic                                cfg_we,
    input  wire logic [tlr_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  wire logic [tlr_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
    import tlr_pkg::*;

    cfg_t               cfg_reg;
    logic               item_valid;
    in_beat_t           item;
    logic               space;
    logic               advance;
    res_t               res;
    logic [LEVEL_W-1:0] level_q;

    // configuration registers, writes past the list are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ramp_step   <= STEP_W'(1);
            cfg_reg.ramp_target <= '0;
            cfg_reg.tick_period <= TICK_W'(1);
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_RAMP_STEP:   cfg_reg.ramp_step   <= cfg_wdata[STEP_W-1:0];
                CFG_RAMP_TARGET: cfg_reg.ramp_target <= cfg_wdata[LEVEL_W-1:0];
                CFG_TICK_PERIOD: cfg_reg.tick_period <= cfg_wdata[TICK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // a held request is processed once the result register can take a beat
    assign advance = item_valid && space;

    tlr_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_payload  (s_payload),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    tlr_ramp_core #(
        .PERIOD_BITS (PERIOD_BITS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (advance),
        .item    (item),
        .cfg     (cfg_reg),
        .res     (res),
        .level_q (level_q)
    );

    tlr_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res       (res),
        .space     (space),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

`ifndef SYNTH
    // stored level stays within percent range
    a_level_range: assert property (@(posedge aclk) disable iff (!aresetn)
        level_q <= LEVEL_MAX)
        else $error("ramp level above full scale");

    // a new output beat only follows a processed request
    a_beat_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(advance))
        else $error("output beat without a processed request");

    // final beat carries the clamped target and a dormant phase
    a_done_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_payload.ramp_done) |->
            (m_payload.level_out == clamp_level(cfg_reg.ramp_target) && !m_payload.ramping))
        else $error("final beat differs from target");
`endif

endmodule

`default_nettype wire

// ----- design/tlr_in_stage.sv -----
// input register holding one accepted request beat
`default_nettype none

module tlr_in_stage (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire tlr_pkg::in_beat_t s_payload,
    input  wire logic             advance,
    output logic                  item_valid,
    output tlr_pkg::in_beat_t     item
);
    import tlr_pkg::*;

    logic     valid_reg, valid_next;
    in_beat_t data_reg;

    assign s_ready    = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = data_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg <= s_payload;
        end
    end

endmodule

`default_nettype wire

// ----- design/tlr_ramp_core.sv -----
// ramp state registers and single-pass update for one request
`default_nettype none

module tlr_ramp_core #(
    parameter int PERIOD_BITS = tlr_pkg::PERIOD_BITS_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              fire,
    input  wire tlr_pkg::in_beat_t item,
    input  wire tlr_pkg::cfg_t     cfg,
    output tlr_pkg::res_t          res,
    output logic [tlr_pkg::LEVEL_W-1:0] level_q
);
    import tlr_pkg::*;

    logic                   phase_reg, phase_next;
    logic [LEVEL_W-1:0]     level_reg, level_next;
    logic [PERIOD_BITS-1:0] countdown_reg, countdown_next;
    logic                   abort_reg, abort_next;

    logic [PERIOD_BITS+TICK_W-1:0] period_ext;
    logic [PERIOD_BITS-1:0]        period_cut;
    logic [PERIOD_BITS-1:0]        period_load;
    logic [LEVEL_W-1:0]            tgt;
    logic                          step_neg;
    logic signed [9:0]             sum;
    logic [LEVEL_W-1:0]            stepped;
    logic [LEVEL_W-1:0]            start_lvl;
    logic                          reached;

    assign level_q = level_reg;

    // tick period cut to the counter width, zero acts as one
    assign period_ext  = {{PERIOD_BITS{1'b0}}, cfg.tick_period};
    assign period_cut  = period_ext[PERIOD_BITS-1:0];
    assign period_load = (period_cut == '0) ? PERIOD_BITS'(1) : period_cut;

    assign tgt      = clamp_level(cfg.ramp_target);
    assign step_neg = cfg.ramp_step[STEP_W-1];

    // saturated level plus step
    assign sum = $signed({3'b000, level_reg}) + $signed({{2{cfg.ramp_step[STEP_W-1]}},
                                                          cfg.ramp_step});
    always_comb begin
        if (sum[9]) begin
            stepped = '0;
        end else if (sum[8:0] > {2'b00, LEVEL_MAX}) begin
            stepped = LEVEL_MAX;
        end else begin
            stepped = sum[LEVEL_W-1:0];
        end
    end

    assign reached = step_neg ? (stepped <= tgt) : (stepped >= tgt);

    always_comb begin
        phase_next     = phase_reg;
        level_next     = level_reg;
        countdown_next = countdown_reg;
        abort_next     = abort_reg;
        res            = '0;
        start_lvl      = item.load_level ? clamp_level(item.start_level) : level_reg;
        if (fire) begin
            if (!phase_reg) begin
                if (item.req_type == REQ_START) begin
                    // clamp toward target
                    if (!step_neg && (start_lvl > tgt)) begin
                        level_next = tgt;
                    end else if (step_neg && (start_lvl < tgt)) begin
                        level_next = tgt;
                    end else begin
                        level_next = start_lvl;
                    end
                    phase_next          = 1'b1;
                    abort_next          = 1'b0;
                    countdown_next      = period_load;
                    res.valid           = 1'b1;
                    res.beat.level_out  = level_next;
                    res.beat.ramp_done  = 1'b0;
                    res.beat.ramping    = 1'b1;
                end
            end else begin
                unique case (item.req_type)
                    REQ_STOP: begin
                        level_next = stepped;
                        phase_next = 1'b0;
                        abort_next = 1'b0;
                    end
                    REQ_START: begin
                        abort_next = 1'b1;
                    end
                    REQ_TICK: begin
                        if (countdown_reg > PERIOD_BITS'(1)) begin
                            countdown_next = countdown_reg - PERIOD_BITS'(1);
                        end else begin
                            countdown_next = '0;
                            level_next     = stepped;
                            if (abort_reg) begin
                                phase_next = 1'b0;
                                abort_next = 1'b0;
                            end else if (reached) begin
                                level_next         = tgt;
                                phase_next         = 1'b0;
                                res.valid          = 1'b1;
                                res.beat.level_out = tgt;
                                res.beat.ramp_done = 1'b1;
                                res.beat.ramping   = 1'b0;
                            end else begin
                                countdown_next     = period_load;
                                res.valid          = 1'b1;
                                res.beat.level_out = stepped;
                                res.beat.ramp_done = 1'b0;
                                res.beat.ramping   = 1'b1;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= 1'b0;
            level_reg     <= '0;
            countdown_reg <= '0;
            abort_reg     <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            level_reg     <= level_next;
            countdown_reg <= countdown_next;
            abort_reg     <= abort_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/tlr_out_stage.sv -----
// result register in front of the output channel
`default_nettype none

module tlr_out_stage (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire tlr_pkg::res_t  res,
    output logic                space,
    output logic                m_valid,
    input  wire logic           m_ready,
    output tlr_pkg::out_beat_t  m_payload
);
    import tlr_pkg::*;

    logic      valid_reg, valid_next;
    out_beat_t data_reg;

    assign space     = !valid_reg || m_ready;
    assign m_valid   = valid_reg;
    assign m_payload = data_reg;

    always_comb begin
        valid_next = valid_reg;
        if (res.valid) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res.valid) begin
            data_reg <= res.beat;
        end
    end

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// testbench for the timed level ramp: directed table and random ramps checked by a level predictor
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tlr_pkg::*;

    localparam int PERIOD_BITS     = PERIOD_BITS_DEF;
    localparam logic [1:0] REQ_SPARE = 2'd3;   // unused request code, ignored by the block
    localparam int DRAIN_CYCLES    = 6;         // drain margin after the last owed beat
    localparam int HOLD_CYCLES     = 300;       // long receiver hold-off to back up the pipe
    localparam int RAND_PHASES     = 10;
    localparam int ITEMS_PER_PHASE = 160;       // request beats taken, per random phase
    localparam int RUN_LIMIT_NS    = 1000000;

    // directed table row: either a register setting or one request beat
    typedef struct {
        bit        is_cfg;
        int        a;       // req_type, or ramp_step
        int        b;       // load_level, or ramp_target
        int        c;       // start_level, or tick_period
        bit        pinned;  // expected beat typed in below
        out_beat_t want;
    } dir_row_t;

    // per accepted request: typed-in expectation, if any
    typedef struct packed {
        logic      pinned;
        out_beat_t want;
    } pin_t;

    // clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    // request channel
    logic     s_valid   = 1'b0;
    logic     s_ready;
    in_beat_t s_payload = '0;

    // level channel
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_beat_t m_payload;

    // register write port
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // predictor copy of registers and ramp state, reset values
    int step_cfg    = 1;
    int target_cfg  = 0;
    int period_cfg  = 1;
    bit ramp_on     = 1'b0;
    int cur_level   = 0;
    int ticks_left  = 0;
    bit abort_armed = 1'b0;

    out_beat_t level_beats_q [$];   // level beats still owed by the block
    pin_t      pinned_q      [$];   // one entry per offered request, in order
    int        mismatches    = 0;
    int        sent_items    = 0;   // request beats taken by the block

    // idling controls shared with the receiver
    bit s_free  = 1'b0;
    bit m_free  = 1'b0;
    bit hold_rx = 1'b0;

    dir_row_t dir_tab [$];

    timed_level_ramp_top #(
        .PERIOD_BITS(PERIOD_BITS)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // 2 ns clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic int clip_pct(input int v);
        if (v < 0) begin
            return 0;
        end
        if (v > int'(LEVEL_MAX)) begin
            return int'(LEVEL_MAX);
        end
        return v;
    endfunction

    // one request against the ramp state: updates it and reports the level beat, if any
    task automatic advance_ramp(input in_beat_t b, output bit made, output out_beat_t res);
        int tgt;
        int reload;
        made   = 1'b0;
        res    = '0;
        tgt    = clip_pct(target_cfg);
        reload = int'(longint'(period_cfg) & ((64'd1 << PERIOD_BITS) - 64'd1));
        if (reload == 0) begin
            reload = 1;
        end

        if (!ramp_on) begin
            // dormant: only a start does anything
            if (b.req_type != REQ_START) begin
                return;
            end
            if (b.load_level) begin
                cur_level = clip_pct(int'(b.start_level));
            end
            // clamp toward the target from the side the step moves away from
            if (step_cfg >= 0) begin
                if (cur_level > tgt) begin
                    cur_level = tgt;
                end
            end else if (cur_level < tgt) begin
                cur_level = tgt;
            end
            ramp_on     = 1'b1;
            abort_armed = 1'b0;
            ticks_left  = reload;
            made        = 1'b1;
            res         = '{level_out: cur_level[LEVEL_W-1:0], ramp_done: 1'b0, ramping: 1'b1};
            return;
        end

        if (b.req_type == REQ_STOP) begin
            // immediate abort, step still applied
            cur_level   = clip_pct(cur_level + step_cfg);
            ramp_on     = 1'b0;
            abort_armed = 1'b0;
            return;
        end
        if (b.req_type == REQ_START) begin
            abort_armed = 1'b1;
            return;
        end
        if (b.req_type != REQ_TICK) begin
            return;
        end

        if (ticks_left > 1) begin
            ticks_left--;
            return;
        end

        // countdown expired
        ticks_left = 0;
        cur_level  = clip_pct(cur_level + step_cfg);
        if (abort_armed) begin
            ramp_on     = 1'b0;
            abort_armed = 1'b0;
            return;
        end
        if ((step_cfg >= 0 && cur_level >= tgt) || (step_cfg < 0 && cur_level <= tgt)) begin
            cur_level = tgt;
            ramp_on   = 1'b0;
            made      = 1'b1;
            res       = '{level_out: cur_level[LEVEL_W-1:0], ramp_done: 1'b1, ramping: 1'b0};
            return;
        end
        ticks_left = reload;
        made       = 1'b1;
        res        = '{level_out: cur_level[LEVEL_W-1:0], ramp_done: 1'b0, ramping: 1'b1};
    endtask

    function automatic in_beat_t mk_beat(input int req, input int load, input int lvl);
        in_beat_t b;
        b.req_type    = req[1:0];
        b.load_level  = load[0];
        b.start_level = lvl[LEVEL_W-1:0];
        return b;
    endfunction

    function automatic dir_row_t row(input bit is_cfg, input int a, input int b, input int c,
                                     input bit pin, input int lvl, input bit done,
                                     input bit rmp);
        dir_row_t r;
        r.is_cfg         = is_cfg;
        r.a              = a;
        r.b              = b;
        r.c              = c;
        r.pinned         = pin;
        r.want.level_out = lvl[LEVEL_W-1:0];
        r.want.ramp_done = done;
        r.want.ramping   = rmp;
        return r;
    endfunction

    // offer one request beat after a random gap, return at the edge that takes it
    task automatic send_beat(input in_beat_t b, input bit pinned, input out_beat_t want);
        int gap;
        pin_t p;
        gap      = s_free ? 0 : int'($urandom_range(0, 17));
        p.pinned = pinned;
        p.want   = want;
        pinned_q.push_back(p);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= b;
        do @(posedge aclk); while (!s_ready);
    endtask

    // drop valid and let every owed beat and any silent request drain out
    task automatic wait_idle();
        s_valid <= 1'b0;
        repeat (2) @(posedge aclk);
        while (level_beats_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // write all three registers, junk in the unused upper bits
    task automatic apply_settings(input int st, input int tg, input int pr);
        logic [15:0]        junk;
        logic [STEP_W-1:0]  st8;
        logic [LEVEL_W-1:0] tg7;
        logic [TICK_W-1:0]  pr16;
        junk = 16'($urandom);
        st8  = st[STEP_W-1:0];
        tg7  = tg[LEVEL_W-1:0];
        pr16 = pr[TICK_W-1:0];
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_RAMP_STEP;
        cfg_wdata <= {junk[15:8], st8};
        @(posedge aclk);
        cfg_addr  <= CFG_RAMP_TARGET;
        cfg_wdata <= {junk[8:0], tg7};
        @(posedge aclk);
        cfg_addr  <= CFG_TICK_PERIOD;
        cfg_wdata <= pr16;
        @(posedge aclk);
        cfg_we     <= 1'b0;
        step_cfg   = int'(signed'(st8));
        target_cfg = int'(tg7);
        period_cfg = int'(pr16);
    endtask

    // monitor: predict on every accepted request, check every accepted level beat
    always @(posedge aclk) begin
        pin_t      pin;
        bit        made;
        out_beat_t res;
        out_beat_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                pin = pinned_q.pop_front();
                advance_ramp(s_payload, made, res);
                sent_items++;
                // a typed-in expectation takes the place of the predicted one
                if (pin.pinned) begin
                    level_beats_q.push_back(pin.want);
                end else if (made) begin
                    level_beats_q.push_back(res);
                end
            end
            if (m_valid && m_ready) begin
                if (level_beats_q.size() == 0) begin
                    $display("%0t unexpected level beat: expected none actual %0d/%0d/%0d",
                             $time, m_payload.level_out, m_payload.ramp_done,
                             m_payload.ramping);
                    mismatches++;
                end else begin
                    want = level_beats_q.pop_front();
                    if (m_payload.level_out !== want.level_out) begin
                        $display("%0t level_out mismatch: expected %0d actual %0d",
                                 $time, want.level_out, m_payload.level_out);
                        mismatches++;
                    end
                    if (m_payload.ramp_done !== want.ramp_done) begin
                        $display("%0t ramp_done mismatch: expected %0d actual %0d",
                                 $time, want.ramp_done, m_payload.ramp_done);
                        mismatches++;
                    end
                    if (m_payload.ramping !== want.ramping) begin
                        $display("%0t ramping mismatch: expected %0d actual %0d",
                                 $time, want.ramping, m_payload.ramping);
                        mismatches++;
                    end
                end
            end
        end
    end

    // receiver: random stall per beat, plus one long hold-off on request
    initial begin : level_sink
        int stall;
        wait (aresetn === 1'b1);
        forever begin
            if (hold_rx) begin
                // block fills up and must drop s_ready
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_rx = 1'b0;
            end
            stall = m_free ? 0 : int'($urandom_range(0, 17));
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // run limit
    initial begin
        #(RUN_LIMIT_NS);
        $display("FAILURE");
        $finish;
    end

    // stimulus
    initial begin : stim
        int        ph;
        int        goal;
        int        k;
        int        pick;
        int        st;
        int        tg;
        int        pr;
        int        req;
        out_beat_t none;
        none = '0;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part, reset register values first: step 1, target 0, period 1
        dir_tab.push_back(row(0, REQ_TICK,  0, 0,   0, 0, 0, 0));  // tick while dormant
        dir_tab.push_back(row(0, REQ_STOP,  1, 100, 0, 0, 0, 0));  // stop while dormant
        dir_tab.push_back(row(0, REQ_SPARE, 1, 127, 0, 0, 0, 0));  // unused code
        dir_tab.push_back(row(0, REQ_START, 0, 0,   1, 0, 0, 1));  // start from reset level
        dir_tab.push_back(row(0, REQ_TICK,  0, 0,   1, 0, 1, 0));  // overshoot ends at target
        dir_tab.push_back(row(0, REQ_START, 1, 127, 1, 0, 0, 1));  // start level over 100
        dir_tab.push_back(row(0, REQ_STOP,  0, 0,   0, 0, 0, 0));  // stop while ramping
        // largest up step, top target, period zero acts as one
        dir_tab.push_back(row(1, 100, 100, 0,       0, 0, 0, 0));
        dir_tab.push_back(row(0, REQ_START, 1, 0,   1, 0, 0, 1));
        dir_tab.push_back(row(0, REQ_TICK,  0, 0,   1, 100, 1, 0));
        // largest down step, bottom target
        dir_tab.push_back(row(1, -100, 0, 2,        0, 0, 0, 0));
        dir_tab.push_back(row(0, REQ_START, 0, 0,   0, 0, 0, 0));
        dir_tab.push_back(row(0, REQ_TICK,  1, 99,  0, 0, 0, 0));  // countdown only
        dir_tab.push_back(row(0, REQ_SPARE, 0, 3,   0, 0, 0, 0));  // unused code while ramping
        dir_tab.push_back(row(0, REQ_TICK,  0, 0,   1, 0, 1, 0));
        dir_tab.push_back(row(0, REQ_START, 1, 50,  0, 0, 0, 0));
        dir_tab.push_back(row(0, REQ_START, 0, 0,   0, 0, 0, 0));  // start during ramp arms abort
        dir_tab.push_back(row(0, REQ_TICK,  0, 0,   0, 0, 0, 0));
        dir_tab.push_back(row(0, REQ_TICK,  0, 0,   0, 0, 0, 0));  // silent abort at expiry
        // zero step, target over 100, longest period
        dir_tab.push_back(row(1, 0, 127, 65535,     0, 0, 0, 0));
        dir_tab.push_back(row(0, REQ_START, 1, 40,  0, 0, 0, 0));
        dir_tab.push_back(row(0, REQ_TICK,  0, 0,   0, 0, 0, 0));
        dir_tab.push_back(row(0, REQ_STOP,  0, 0,   0, 0, 0, 0));
        // zero step ends only on equality
        dir_tab.push_back(row(1, 0, 40, 1,          0, 0, 0, 0));
        dir_tab.push_back(row(0, REQ_START, 0, 0,   0, 0, 0, 0));
        dir_tab.push_back(row(0, REQ_TICK,  0, 0,   0, 0, 0, 0));
        // down step with low start level clamps up to the target
        dir_tab.push_back(row(1, -1, 127, 1,        0, 0, 0, 0));
        dir_tab.push_back(row(0, REQ_START, 1, 5,   0, 0, 0, 0));
        dir_tab.push_back(row(0, REQ_TICK,  0, 0,   0, 0, 0, 0));

        foreach (dir_tab[i]) begin
            if (dir_tab[i].is_cfg) begin
                wait_idle();
                apply_settings(dir_tab[i].a, dir_tab[i].b, dir_tab[i].c);
            end else begin
                send_beat(mk_beat(dir_tab[i].a, dir_tab[i].b, dir_tab[i].c),
                          dir_tab[i].pinned, dir_tab[i].want);
            end
        end

        // random part: ramps with random content, some noise and broken sequences
        for (ph = 0; ph < RAND_PHASES; ph++) begin
            wait_idle();
            s_free = (ph % 4 == 1);
            m_free = (ph % 4 == 2);
            if (ph == 3) begin
                // slow up ramp, a beat on every tick, receiver holds off
                apply_settings(1, 100, 0);
                s_free  = 1'b1;
                hold_rx = 1'b1;
            end else begin
                pick = $urandom_range(0, 9);
                if (pick == 0) begin
                    st = 0;
                end else if (pick < 4) begin
                    st = int'($urandom_range(1, 5));
                    if ($urandom_range(0, 1) == 0) begin
                        st = -st;
                    end
                end else begin
                    st = int'($urandom_range(0, 200)) - 100;
                end
                tg = $urandom_range(0, 127);
                if ($urandom_range(0, 7) == 0) begin
                    pr = $urandom_range(5, 40);
                end else begin
                    pr = $urandom_range(0, 4);
                end
                apply_settings(st, tg, pr);
            end

            goal = sent_items + ITEMS_PER_PHASE;
            while (sent_items < goal) begin
                if ($urandom_range(0, 9) == 0) begin
                    // stray request ahead of the ramp
                    send_beat(mk_beat($urandom_range(0, 3), $urandom_range(0, 1),
                                      $urandom_range(0, 127)), 1'b0, none);
                end
                send_beat(mk_beat(REQ_START, $urandom_range(0, 1), $urandom_range(0, 127)),
                          1'b0, none);
                k = $urandom_range(1, 30);
                repeat (k) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 85) begin
                        req = REQ_TICK;
                    end else if (pick < 90) begin
                        req = REQ_START;
                    end else if (pick < 95) begin
                        req = REQ_STOP;
                    end else begin
                        req = REQ_SPARE;
                    end
                    send_beat(mk_beat(req, $urandom_range(0, 1), $urandom_range(0, 127)),
                              1'b0, none);
                end
            end
        end

        wait_idle();
        if (mismatches == 0 && level_beats_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

`default_nettype wire
